@@ design/vrg_pkg.sv @@
// vrg_pkg: shared types and constants of the velocity ramp generator.
// Used by vrg_alu, vrg_ctrl and velocity_ramp_generator; depends on nothing.
package vrg_pkg;

   // register file widths
   localparam int STEP_CFG_WIDTH = 15;
   localparam int GAIN_CFG_WIDTH = 16;
   localparam int CSR_IDX_WIDTH  = 8;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int FRAC_BITS      = 12;

   // gains are unsigned q4.12, limited to 10.0
   localparam logic [GAIN_CFG_WIDTH-1:0] GAIN_LIMIT = 16'd40960;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAX_SPEED  = 8'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DECEL_STEP = 8'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ACCEL_BASE = 8'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_GAIN_START = 8'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_GAIN_NEAR  = 8'd4;

   // reset values of the registers
   localparam logic [STEP_CFG_WIDTH-1:0] MAX_SPEED_RST  = 15'd8192;
   localparam logic [STEP_CFG_WIDTH-1:0] DECEL_STEP_RST = 15'd41;
   localparam logic [STEP_CFG_WIDTH-1:0] ACCEL_BASE_RST = 15'd20;
   localparam logic [GAIN_CFG_WIDTH-1:0] GAIN_START_RST = 16'd8192;
   localparam logic [GAIN_CFG_WIDTH-1:0] GAIN_NEAR_RST  = 16'd4096;

   typedef struct packed {
      logic [STEP_CFG_WIDTH-1:0] max_speed;
      logic [STEP_CFG_WIDTH-1:0] decel_step;
      logic [STEP_CFG_WIDTH-1:0] accel_unit;
      logic [GAIN_CFG_WIDTH-1:0] gain_start;
      logic [GAIN_CFG_WIDTH-1:0] gain_near;
   } vrg_cfg_type;

   typedef enum logic [1:0] {
      ALU_NOP = 2'd0,
      ALU_MAC = 2'd1,
      ALU_DIV = 2'd2
   } vrg_op_type;

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b00_0000_0001,
      ST_DECIDE   = 10'b00_0000_0010,
      ST_MUL_S    = 10'b00_0000_0100,
      ST_MUL_F    = 10'b00_0000_1000,
      ST_MUL_LO   = 10'b00_0001_0000,
      ST_MUL_HI   = 10'b00_0010_0000,
      ST_DIV_INIT = 10'b00_0100_0000,
      ST_DIV_STEP = 10'b00_1000_0000,
      ST_RAMP     = 10'b01_0000_0000,
      ST_FINISH   = 10'b10_0000_0000
   } vrg_state_type;

endpackage

@@ design/vrg_alu.sv @@
// vrg_alu: shared arithmetic unit, a 32x16 multiply-accumulate and one
// restoring divide step. Depends on vrg_pkg.
module vrg_alu
   import vrg_pkg::*;
#(
   parameter int SPEED_WIDTH = 16,
   parameter int ACC_WIDTH   = 46
) (
   input  vrg_op_type                  op,
   input  logic [31:0]                 mul_a,
   input  logic [15:0]                 mul_b,
   input  logic                        mul_hi,
   input  logic [ACC_WIDTH-1:0]        acc_in,
   output logic [ACC_WIDTH-1:0]        acc_out,
   input  logic [2*SPEED_WIDTH-1:0]    div_x_in,
   input  logic [SPEED_WIDTH-2:0]      div_d,
   output logic [2*SPEED_WIDTH-1:0]    div_x_out
);

   localparam int W = SPEED_WIDTH;

   logic [47:0]          prod;
   logic [79:0]          prod_sh;
   logic [2*W-1:0]       x_sh;
   logic [W:0]           trial;

   always_comb begin
      prod    = mul_a * mul_b;
      prod_sh = mul_hi ? (80'(prod) << 32) : 80'(prod);
      x_sh    = {div_x_in[2*W-2:0], 1'b0};
      trial   = {1'b0, x_sh[2*W-1:W]} - {2'b00, div_d};
      acc_out   = acc_in;
      div_x_out = div_x_in;
      unique case (op)
         ALU_MAC: begin
            acc_out = acc_in + prod_sh[ACC_WIDTH-1:0];
         end
         ALU_DIV: begin
            // partial remainder stays below the divisor, so the top bit is free
            if (!trial[W]) begin
               div_x_out = {trial[W-1:0], x_sh[W-1:1], 1'b1};
            end else begin
               div_x_out = x_sh;
            end
         end
         default: begin
            acc_out   = acc_in;
            div_x_out = div_x_in;
         end
      endcase
   end

endmodule

@@ design/vrg_ctrl.sv @@
// vrg_ctrl: sequencer and datapath registers of the velocity ramp generator.
// Depends on vrg_pkg and vrg_alu.
module vrg_ctrl
   import vrg_pkg::*;
#(
   parameter int SPEED_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  vrg_cfg_type                   cfg,
   input  logic                          start,
   input  logic signed [SPEED_WIDTH-1:0] start_target,
   input  logic                          start_hard,
   output logic                          idle,
   output logic                          res_valid,
   input  logic                          res_ready,
   output logic signed [SPEED_WIDTH-1:0] res_speed
);

   localparam int W   = SPEED_WIDTH;
   localparam int STW = (W > STEP_CFG_WIDTH) ? W : STEP_CFG_WIDTH;
   localparam int NW  = W - 1 + GAIN_CFG_WIDTH;
   localparam int AW  = NW + STEP_CFG_WIDTH;
   localparam int HW  = AW - FRAC_BITS - W;
   localparam int CW  = $clog2(W);
   localparam logic [31:0] SPD_MAX32 = 32'((64'd1 << (W - 1)) - 64'd1);

   vrg_state_type         state_ff, state_in;
   logic signed [W-1:0]   tgt_ff, tgt_in;
   logic                  hard_ff, hard_in;
   logic signed [W-1:0]   cur_ff, cur_in;
   logic signed [W-1:0]   base_ff, base_in;
   logic [W-2:0]          cmag_ff, cmag_in;
   logic [NW-1:0]         wsum_ff, wsum_in;
   logic [AW-1:0]         prod_ff, prod_in;
   logic [2*W-1:0]        quo_ff, quo_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic signed [W-1:0]   nxt_ff, nxt_in;

   vrg_op_type            alu_op;
   logic [31:0]           alu_a;
   logic [15:0]           alu_b;
   logic                  alu_hi;
   logic [AW-1:0]         alu_acc;
   logic [AW-1:0]         alu_acc_out;
   logic [2*W-1:0]        alu_x_out;

   logic [31:0]           lim32;
   logic signed [W:0]     lim_x;
   logic signed [W:0]     req_x;
   logic signed [W:0]     clamp_x;
   logic [W-1:0]          tabs;
   logic [W-1:0]          cabs;
   logic [W-2:0]          tmag;
   logic [GAIN_CFG_WIDTH-1:0] fast_lim;
   logic [GAIN_CFG_WIDTH-1:0] slow_lim;
   logic [STW-1:0]        brk_step;
   logic signed [W-1:0]   brk_to_zero;
   logic signed [W-1:0]   brk_to_tgt;
   logic                  reversal;
   logic [63:0]           wsum_pad;
   logic [HW-1:0]         quo_hi;

   // move cur toward goal by step, never past goal; a zero step jumps to goal
   function automatic logic signed [W-1:0] ramp_f(
      input logic signed [W-1:0] cur,
      input logic signed [W-1:0] goal,
      input logic [STW-1:0]      step
   );
      logic signed [STW+1:0] c_x;
      logic signed [STW+1:0] g_x;
      logic signed [STW+1:0] s_x;
      logic signed [STW+1:0] t_x;
      logic signed [STW+1:0] r_x;
      c_x = (STW+2)'(cur);
      g_x = (STW+2)'(goal);
      s_x = $signed({2'b00, step});
      if (step == '0) begin
         r_x = g_x;
      end else if (c_x < g_x) begin
         t_x = c_x + s_x;
         r_x = (t_x > g_x) ? g_x : t_x;
      end else if (c_x > g_x) begin
         t_x = c_x - s_x;
         r_x = (t_x < g_x) ? g_x : t_x;
      end else begin
         r_x = c_x;
      end
      return r_x[W-1:0];
   endfunction

   vrg_alu #(
      .SPEED_WIDTH (W),
      .ACC_WIDTH   (AW)
   ) u_alu (
      .op        (alu_op),
      .mul_a     (alu_a),
      .mul_b     (alu_b),
      .mul_hi    (alu_hi),
      .acc_in    (alu_acc),
      .acc_out   (alu_acc_out),
      .div_x_in  (quo_ff),
      .div_d     (tmag),
      .div_x_out (alu_x_out)
   );

   // target clamp to +/- min(max_speed, largest speed)
   always_comb begin
      lim32   = (32'(cfg.max_speed) > SPD_MAX32) ? SPD_MAX32 : 32'(cfg.max_speed);
      lim_x   = $signed({2'b00, lim32[W-2:0]});
      req_x   = (W+1)'(start_target);
      if (req_x > lim_x) begin
         clamp_x = lim_x;
      end else if (req_x < -lim_x) begin
         clamp_x = -lim_x;
      end else begin
         clamp_x = req_x;
      end
   end

   always_comb begin
      tabs        = tgt_ff[W-1] ? W'(-tgt_ff) : W'(tgt_ff);
      cabs        = cur_ff[W-1] ? W'(-cur_ff) : W'(cur_ff);
      tmag        = tabs[W-2:0];
      fast_lim    = (cfg.gain_start > GAIN_LIMIT) ? GAIN_LIMIT : cfg.gain_start;
      slow_lim    = (cfg.gain_near > GAIN_LIMIT) ? GAIN_LIMIT : cfg.gain_near;
      brk_step    = STW'(cfg.decel_step);
      brk_to_zero = ramp_f(cur_ff, '0, brk_step);
      brk_to_tgt  = ramp_f(cur_ff, tgt_ff, brk_step);
      reversal    = (cur_ff < 0 && tgt_ff > 0) || (cur_ff > 0 && tgt_ff < 0);
      wsum_pad    = 64'(wsum_ff);
      quo_hi      = prod_ff[AW-1:W+FRAC_BITS];
   end

   always_comb begin
      state_in = state_ff;
      tgt_in   = tgt_ff;
      hard_in  = hard_ff;
      cur_in   = cur_ff;
      base_in  = base_ff;
      cmag_in  = cmag_ff;
      wsum_in  = wsum_ff;
      prod_in  = prod_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      nxt_in   = nxt_ff;
      alu_op   = ALU_NOP;
      alu_a    = '0;
      alu_b    = '0;
      alu_hi   = 1'b0;
      alu_acc  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               tgt_in   = clamp_x[W-1:0];
               hard_in  = start_hard;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_FINISH;
            if (hard_ff) begin
               nxt_in = tgt_ff;
            end else if (tgt_ff == '0) begin
               nxt_in = brk_to_zero;
            end else if (reversal && brk_to_zero != '0) begin
               nxt_in = brk_to_zero;
            end else if (!reversal && tabs < cabs) begin
               nxt_in = brk_to_tgt;
            end else if (cfg.accel_unit == '0) begin
               nxt_in = tgt_ff;
            end else begin
               // reversal that reached zero accelerates from standstill
               base_in  = reversal ? '0 : cur_ff;
               cmag_in  = reversal ? '0 : cabs[W-2:0];
               state_in = ST_MUL_S;
            end
         end
         ST_MUL_S: begin
            alu_op   = ALU_MAC;
            alu_a    = 32'(cmag_ff);
            alu_b    = slow_lim;
            wsum_in  = alu_acc_out[NW-1:0];
            state_in = ST_MUL_F;
         end
         ST_MUL_F: begin
            alu_op   = ALU_MAC;
            alu_a    = 32'(tmag - cmag_ff);
            alu_b    = fast_lim;
            alu_acc  = AW'(wsum_ff);
            wsum_in  = alu_acc_out[NW-1:0];
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            alu_op   = ALU_MAC;
            alu_a    = wsum_pad[31:0];
            alu_b    = 16'(cfg.accel_unit);
            prod_in  = alu_acc_out;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            alu_op   = ALU_MAC;
            alu_a    = wsum_pad[63:32];
            alu_b    = 16'(cfg.accel_unit);
            alu_hi   = 1'b1;
            alu_acc  = prod_ff;
            prod_in  = alu_acc_out;
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cnt_in = '0;
            // quotient of (product >> 12) / t would not fit the speed width
            if (64'(quo_hi) >= 64'(tmag)) begin
               quo_in   = {{W{1'b0}}, {W{1'b1}}};
               state_in = ST_RAMP;
            end else begin
               quo_in   = {W'(quo_hi), prod_ff[W+FRAC_BITS-1:FRAC_BITS]};
               state_in = ST_DIV_STEP;
            end
         end
         ST_DIV_STEP: begin
            alu_op = ALU_DIV;
            quo_in = alu_x_out;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(W - 1)) begin
               state_in = ST_RAMP;
            end
         end
         ST_RAMP: begin
            nxt_in   = ramp_f(base_ff, tgt_ff, STW'(quo_ff[W-1:0]));
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (res_ready) begin
               cur_in   = nxt_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cur_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff  <= tgt_in;
      hard_ff <= hard_in;
      base_ff <= base_in;
      cmag_ff <= cmag_in;
      wsum_ff <= wsum_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      nxt_ff  <= nxt_in;
   end

   assign idle      = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_FINISH);
   assign res_speed = nxt_ff;

endmodule

@@ design/velocity_ramp_generator.sv @@
// velocity_ramp_generator: top level with register file and result register.
// Depends on vrg_pkg, vrg_ctrl and vrg_alu.
//
// Each request carries a signed target speed and a hard-reset flag and gives
// one response, the ramped speed after that tick (signed, 12 fraction bits).
// The request channel takes one request at a time: req_ready is high only
// while the sequencer is idle. A request that accelerates runs the shared
// multiply-accumulate unit four times and then, unless the quotient would
// overflow the speed width, the divide step SPEED_WIDTH times; the next
// request is taken only after its response has left the sequencer. Hard
// reset, braking, reversal braking that stops short of zero and a zero base
// step skip the arithmetic. The response sits in an output register; the
// next request is taken while it waits. If the receiver stalls, a finished
// result holds in the sequencer until the output register frees, and the
// speed state advances only then. Registers are to be written on the csr
// channel (always ready) only while no request is in flight; the user must
// keep to this, as the block does not enforce it. Indexes 0..4 are the
// speed limit, braking step, base acceleration step, standstill gain and
// near-target gain, others are ignored. Reset zeroes the speed, loads the
// register reset values and empties the output register.
module velocity_ramp_generator
   import vrg_pkg::*;
#(
   parameter int SPEED_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SPEED_WIDTH-1:0] req_target_speed,
   input  logic                          req_hard_reset,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SPEED_WIDTH-1:0] rsp_speed_out,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0]      csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_wdata
);

   vrg_cfg_type                   cfg_ff, cfg_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SPEED_WIDTH-1:0] rsp_speed_ff, rsp_speed_in;

   logic                          ctrl_idle;
   logic                          res_valid;
   logic                          res_ready;
   logic signed [SPEED_WIDTH-1:0] res_speed;

   vrg_ctrl #(
      .SPEED_WIDTH (SPEED_WIDTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .start        (req_valid & ctrl_idle),
      .start_target (req_target_speed),
      .start_hard   (req_hard_reset),
      .idle         (ctrl_idle),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res_speed    (res_speed)
   );

   assign req_ready = ctrl_idle;
   assign csr_ready = 1'b1;
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_SPEED:  cfg_in.max_speed  = csr_wdata[STEP_CFG_WIDTH-1:0];
            CSR_DECEL_STEP: cfg_in.decel_step = csr_wdata[STEP_CFG_WIDTH-1:0];
            CSR_ACCEL_BASE: cfg_in.accel_unit = csr_wdata[STEP_CFG_WIDTH-1:0];
            CSR_GAIN_START: cfg_in.gain_start = csr_wdata[GAIN_CFG_WIDTH-1:0];
            CSR_GAIN_NEAR:  cfg_in.gain_near  = csr_wdata[GAIN_CFG_WIDTH-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_speed_in = rsp_speed_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_speed_in = res_speed;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_speed  <= MAX_SPEED_RST;
         cfg_ff.decel_step <= DECEL_STEP_RST;
         cfg_ff.accel_unit <= ACCEL_BASE_RST;
         cfg_ff.gain_start <= GAIN_START_RST;
         cfg_ff.gain_near  <= GAIN_NEAR_RST;
         rsp_valid_ff      <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_speed_ff <= rsp_speed_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_speed_out = rsp_speed_ff;

endmodule
